### rtl/mtp_pkg.sv
package mtp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;

  // Saturating 2-bit counters (segment length, pending whitespace)
  localparam logic [1:0] SAT2_MAX    = 2'd3;
  localparam logic [1:0] SEG_LEN_OK  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_LENGTH = 3'd2,
    ST_HEX    = 3'd3,
    ST_COUNT  = 3'd4
  } status_t;

  typedef struct packed {
    logic             blank;
    logic             sep;
    logic             hex;
    logic [NIB_W-1:0] nibble;
  } char_class_t;

  typedef struct packed {
    status_t          status;
    logic [MAC_W-1:0] mac_value;
  } result_t;

endpackage

### rtl/mtp_if.sv
interface mtp_in_if;
  logic                       valid;
  logic                       ready;
  logic [mtp_pkg::CHAR_W-1:0] char_code;
  logic                       is_last;

  modport source(output valid, output char_code, output is_last, input ready);
  modport sink(input valid, input char_code, input is_last, output ready);
endinterface

interface mtp_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [mtp_pkg::MAC_W-1:0] mac_value;

  modport source(output valid, output status, output mac_value, input ready);
  modport sink(input valid, input status, input mac_value, output ready);
endinterface

### rtl/mtp_char_class.sv
module mtp_char_class (
  input  logic [mtp_pkg::CHAR_W-1:0] char_code,
  output mtp_pkg::char_class_t       cls
);

  logic is_dec;
  logic is_lower;
  logic is_upper;

  always_comb begin
    is_dec   = (char_code >= mtp_pkg::CHAR_ZERO) && (char_code <= mtp_pkg::CHAR_NINE);
    is_lower = (char_code >= mtp_pkg::CHAR_LA) && (char_code <= mtp_pkg::CHAR_LF);
    is_upper = (char_code >= mtp_pkg::CHAR_UA) && (char_code <= mtp_pkg::CHAR_UF);

    cls.blank = (char_code == mtp_pkg::CHAR_SPACE) ||
                ((char_code >= mtp_pkg::CHAR_TAB) && (char_code <= mtp_pkg::CHAR_CR));
    cls.sep   = (char_code == mtp_pkg::CHAR_COLON) || (char_code == mtp_pkg::CHAR_DASH);
    cls.hex   = is_dec || is_lower || is_upper;

    // Letters: low nibble of 'a'/'A' is 1, so add 9 to get 10..15
    if (is_dec) begin
      cls.nibble = char_code[mtp_pkg::NIB_W-1:0];
    end else begin
      cls.nibble = char_code[mtp_pkg::NIB_W-1:0] + 4'd9;
    end
  end

endmodule

### rtl/mtp_seg_engine.sv
module mtp_seg_engine #(
  parameter int unsigned ADDRESS_BYTES = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 is_last,
  input  mtp_pkg::char_class_t cls,
  output mtp_pkg::result_t     result
);

  localparam int unsigned COUNT_CAP = ADDRESS_BYTES + 1;
  localparam int unsigned CNT_W     = $clog2(COUNT_CAP + 1);
  localparam logic [CNT_W-1:0] CNT_CAP    = CNT_W'(COUNT_CAP);
  localparam logic [CNT_W-1:0] CNT_TARGET = CNT_W'(ADDRESS_BYTES);

  typedef struct packed {
    logic [2:0]                  first_error;
    logic [CNT_W-1:0]            segment_count;
    logic [mtp_pkg::MAC_W-1:0]   address_shift;
  } acc_t;

  logic                         seen_text;
  logic [1:0]                   segment_length;
  logic                         segment_bad_digit;
  logic [mtp_pkg::BYTE_W-1:0]   segment_byte;
  logic [1:0]                   pending_spaces;
  logic [CNT_W-1:0]             segment_count;
  logic [2:0]                   first_error;
  logic [mtp_pkg::MAC_W-1:0]    address_shift;

  logic                         seen_text_next;
  logic [1:0]                   segment_length_next;
  logic                         segment_bad_digit_next;
  logic [mtp_pkg::BYTE_W-1:0]   segment_byte_next;
  logic [1:0]                   pending_spaces_next;
  logic [CNT_W-1:0]             segment_count_next;
  logic [2:0]                   first_error_next;
  logic [mtp_pkg::MAC_W-1:0]    address_shift_next;

  acc_t acc_mid;
  acc_t acc_end;
  logic [2:0] status_code;

  function automatic logic [1:0] sat_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[2] ? mtp_pkg::SAT2_MAX : s[1:0];
  endfunction

  // Judge the open segment and fold it into the accumulated result
  function automatic acc_t close_seg(input acc_t a, input logic [1:0] len,
                                     input logic bad, input logic [mtp_pkg::BYTE_W-1:0] sbyte);
    acc_t r;
    r = a;
    if (a.first_error == 3'(mtp_pkg::ST_OK)) begin
      if (len != mtp_pkg::SEG_LEN_OK) begin
        r.first_error = 3'(mtp_pkg::ST_LENGTH);
      end else if (bad) begin
        r.first_error = 3'(mtp_pkg::ST_HEX);
      end else begin
        r.address_shift = {a.address_shift[mtp_pkg::MAC_W-mtp_pkg::BYTE_W-1:0], sbyte};
        if (a.segment_count < CNT_CAP) begin
          r.segment_count = a.segment_count + CNT_W'(1);
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    seen_text_next         = seen_text;
    segment_length_next    = segment_length;
    segment_bad_digit_next = segment_bad_digit;
    segment_byte_next      = segment_byte;
    pending_spaces_next    = pending_spaces;
    acc_mid = '{first_error: first_error, segment_count: segment_count,
                address_shift: address_shift};

    if (cls.blank) begin
      if (seen_text && (pending_spaces != mtp_pkg::SAT2_MAX)) begin
        pending_spaces_next = pending_spaces + 2'd1;
      end
    end else begin
      seen_text_next = 1'b1;
      if (pending_spaces != 2'd0) begin
        // Interior whitespace: count it into the segment and spoil it
        segment_length_next    = sat_add(segment_length, pending_spaces);
        segment_bad_digit_next = 1'b1;
        pending_spaces_next    = 2'd0;
      end
      if (cls.sep) begin
        acc_mid = close_seg(acc_mid, segment_length_next, segment_bad_digit_next,
                            segment_byte_next);
        segment_length_next    = 2'd0;
        segment_bad_digit_next = 1'b0;
        segment_byte_next      = '0;
      end else begin
        segment_length_next = sat_add(segment_length_next, 2'd1);
        if (cls.hex) begin
          segment_byte_next = {segment_byte_next[mtp_pkg::NIB_W-1:0], cls.nibble};
        end else begin
          segment_bad_digit_next = 1'b1;
        end
      end
    end

    segment_count_next = acc_mid.segment_count;
    first_error_next   = acc_mid.first_error;
    address_shift_next = acc_mid.address_shift;

    // End of text: close the final segment and form the status
    acc_end = close_seg(acc_mid, segment_length_next, segment_bad_digit_next,
                        segment_byte_next);
    if (!seen_text_next) begin
      status_code = 3'(mtp_pkg::ST_EMPTY);
    end else if ((acc_end.first_error == 3'(mtp_pkg::ST_OK)) &&
                 (acc_end.segment_count != CNT_TARGET)) begin
      status_code = 3'(mtp_pkg::ST_COUNT);
    end else begin
      status_code = acc_end.first_error;
    end

    result.status = mtp_pkg::status_t'(status_code);
    if (status_code == 3'(mtp_pkg::ST_OK)) begin
      result.mac_value = acc_end.address_shift;
    end else begin
      result.mac_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      seen_text         <= 1'b0;
      segment_length    <= 2'd0;
      segment_bad_digit <= 1'b0;
      segment_byte      <= '0;
      pending_spaces    <= 2'd0;
      segment_count     <= '0;
      first_error       <= 3'(mtp_pkg::ST_OK);
      address_shift     <= '0;
    end else if (step) begin
      seen_text         <= seen_text_next;
      segment_length    <= segment_length_next;
      segment_bad_digit <= segment_bad_digit_next;
      segment_byte      <= segment_byte_next;
      pending_spaces    <= pending_spaces_next;
      segment_count     <= segment_count_next;
      first_error       <= first_error_next;
      address_shift     <= address_shift_next;
    end
  end

endmodule

### rtl/mac_address_text_parser_top.sv
// MAC address text parser.
//
// Channel chars (sink): one ASCII character per transaction, with is_last
// marking the final character of the text. Channel results (source): one
// transaction per text, carrying status (0 ok, 1 empty, 2 segment length,
// 3 non-hex digit, 4 segment count) and mac_value, first segment in the
// top byte and zero unless the status is ok.
//
// Each character is captured in an input register at the edge that takes
// it, then classified and folded into the segment state when it leaves that
// register; the result of a last character is written to the output register
// at that same edge. One character is taken every cycle, unless a last
// character waits in the input register for a stalled receiver.
//
// A stalled receiver only holds back a last character waiting in the input
// register; ordinary characters keep flowing while a result waits. After a
// result the segment state returns to its reset values, ready for the next
// text. Reset (rst, synchronous) empties both registers and clears state.
module mac_address_text_parser_top #(
  parameter int unsigned ADDRESS_BYTES = 6
) (
  input logic       clk,
  input logic       rst,
  mtp_in_if.sink    chars,
  mtp_out_if.source results
);

  logic                       s1_valid;
  logic [mtp_pkg::CHAR_W-1:0] s1_char;
  logic                       s1_last;

  logic                       out_valid;
  mtp_pkg::result_t           out_data;

  logic                       out_space;
  logic                       s1_go;
  logic                       accept;

  mtp_pkg::char_class_t       cls;
  mtp_pkg::result_t           result;

  // Advance the input register unless it holds a last character with
  // nowhere to put its result
  assign out_space   = !out_valid || results.ready;
  assign s1_go       = s1_valid && (!s1_last || out_space);
  assign chars.ready = !s1_valid || s1_go;
  assign accept      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char <= chars.char_code;
      s1_last <= chars.is_last;
    end
  end

  mtp_char_class u_class (
    .char_code (s1_char),
    .cls       (cls)
  );

  mtp_seg_engine #(
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .is_last (s1_last),
    .cls     (cls),
    .result  (result)
  );

  // Output register: load on a finished text, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_data <= result;
    end
  end

  assign results.valid     = out_valid;
  assign results.status    = 3'(out_data.status);
  assign results.mac_value = out_data.mac_value;

endmodule
